FILE: sv/spsd_pkg.sv
`default_nettype none
package spsd_pkg;

  // Input coordinate format, signed Q8.8 by default.
  localparam int COORD_BITS      = 16;
  // Fraction bits of the segment parameters, unsigned Q1.16 by default.
  localparam int PARAM_FRAC_BITS = 16;
  localparam int PARAM_W         = PARAM_FRAC_BITS + 1;

  // Datapath widths derived from the coordinate format.
  localparam int DIF_W  = COORD_BITS + 1;
  localparam int SQ_W   = 2 * DIF_W;
  localparam int DOT_W  = SQ_W + 1;
  localparam int EDGE_W = DOT_W + 1;
  localparam int PROD_W = 2 * DOT_W;
  localparam int DIV_W  = PROD_W - 2;
  localparam int C_W    = PARAM_W + DIF_W + 3;
  localparam int CSQ_W  = 2 * C_W;
  localparam int DIST_W = 2 * COORD_BITS + 5;
  localparam int EPS_W  = 32;

  // The divider captures its operands, then resolves one quotient bit a stage.
  localparam int DIV_LAT = PARAM_W + 1;

  localparam int IN_TDATA_W  = 8 * COORD_BITS;
  localparam int OUT_FIELD_W = 2 * PARAM_W + DIST_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

  typedef struct packed {
    logic signed [DIF_W-1:0] ux;
    logic signed [DIF_W-1:0] uy;
    logic signed [DIF_W-1:0] vx;
    logic signed [DIF_W-1:0] vy;
    logic signed [DIF_W-1:0] wx;
    logic signed [DIF_W-1:0] wy;
  } vec_t;

  typedef struct packed {
    vec_t vec;
    logic degen;
  } side_t;

endpackage
`default_nettype wire

FILE: sv/segment_pair_distance_squared.sv
// One item per cycle while the output item is taken or absent; the two 18-stage
// quotient dividers make up most of the depth.
// The whole pipeline advances together and holds when the output item is not taken.
// Reset (rst_ni low, asynchronous) clears all valid bits and sets parallel_epsilon to 0.
// No clearing pass is needed; the block accepts items right after reset.
`default_nettype none
module segment_pair_distance_squared (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input items. tdata from bit 0 up: first_start_x, first_start_y, first_end_x,
  // first_end_y, second_start_x, second_start_y, second_end_x, second_end_y.
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [spsd_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // Result items. tdata from bit 0 up: first_param, second_param, dist_squared,
  // then zero padding. tuser bit 0: degenerate.
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic      [spsd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic      [0:0]                        m_axis_tuser_o,
  // parallel_epsilon register.
  input  wire logic                              cfg_wr_en_i,
  input  wire logic [spsd_pkg::EPS_W-1:0]        cfg_wr_data_i
);
  import spsd_pkg::*;

  // Stage map: S1 differences, S2 dot products, S3 wide products, S4 numerators
  // and the denominator, S5 parallel and sn clamping, then the dividers (their
  // operands are chosen in front of the divider capture stage), D1 the
  // difference vector, D2 its squares, and the output register.
  localparam int NSTG    = 5 + DIV_LAT + 3;
  localparam int ST_S5   = 4;
  localparam int ST_DIV  = ST_S5 + DIV_LAT;
  localparam int ST_OUT  = NSTG - 1;

  logic [EPS_W-1:0] eps_q;
  logic             vld_q [0:NSTG-1];
  logic             en;

  // A single enable moves every stage; the output register is the last stage,
  // so a new item enters whenever the result in front is taken or absent.
  assign en              = !vld_q[ST_OUT] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= '0;
    end else if (cfg_wr_en_i) begin
      eps_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // S1: segment direction vectors u, v and the start offset w.
  logic signed [COORD_BITS-1:0] crd [0:7];
  vec_t s1_d, s1_q;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      crd[i] = s_axis_tdata_i[i*COORD_BITS +: COORD_BITS];
    end
    s1_d.ux = DIF_W'(crd[2]) - DIF_W'(crd[0]);
    s1_d.uy = DIF_W'(crd[3]) - DIF_W'(crd[1]);
    s1_d.vx = DIF_W'(crd[6]) - DIF_W'(crd[4]);
    s1_d.vy = DIF_W'(crd[7]) - DIF_W'(crd[5]);
    s1_d.wx = DIF_W'(crd[0]) - DIF_W'(crd[4]);
    s1_d.wy = DIF_W'(crd[1]) - DIF_W'(crd[5]);
  end

  // S2: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w.
  logic signed [SQ_W-1:0] m_uux, m_uuy, m_uvx, m_uvy, m_vvx, m_vvy;
  logic signed [SQ_W-1:0] m_uwx, m_uwy, m_vwx, m_vwy;
  logic signed [DOT_W-1:0] a2_q, b2_q, c2_q, d2_q, e2_q;
  vec_t s2_q;

  assign m_uux = s1_q.ux * s1_q.ux;
  assign m_uuy = s1_q.uy * s1_q.uy;
  assign m_uvx = s1_q.ux * s1_q.vx;
  assign m_uvy = s1_q.uy * s1_q.vy;
  assign m_vvx = s1_q.vx * s1_q.vx;
  assign m_vvy = s1_q.vy * s1_q.vy;
  assign m_uwx = s1_q.ux * s1_q.wx;
  assign m_uwy = s1_q.uy * s1_q.wy;
  assign m_vwx = s1_q.vx * s1_q.wx;
  assign m_vwy = s1_q.vy * s1_q.wy;

  // S3: the products that form the denominator and the two numerators.
  logic signed [PROD_W-1:0] ac3_q, bb3_q, be3_q, cd3_q, ae3_q, bd3_q;
  logic signed [DOT_W-1:0]  a3_q, b3_q, c3_q, d3_q, e3_q;
  vec_t s3_q;

  // S4: denom = ac - bb is never negative, so its magnitude is itself.
  logic signed [PROD_W-1:0] den4_q, sn4_q, tn4_q;
  logic signed [DOT_W-1:0]  a4_q, b4_q, c4_q, d4_q, e4_q;
  logic                     par4_q;
  vec_t s4_q;

  // S5: parallel case and clamping of sn, plus the edge numerators -d and b - d.
  logic signed [PROD_W-1:0] sd5_d, sn5_d, tn5_d, td5_d;
  logic signed [PROD_W-1:0] sd5_q, sn5_q, tn5_q, td5_q;
  logic signed [EDGE_W-1:0] ed0_d, ed1_d, ed0_q, ed1_q;
  logic signed [DOT_W-1:0]  a5_q;
  vec_t s5_q;

  always_comb begin
    ed0_d = -EDGE_W'(d4_q);
    ed1_d = EDGE_W'(b4_q) - EDGE_W'(d4_q);
    if (par4_q) begin
      sd5_d = PROD_W'(c4_q);
      sn5_d = '0;
      tn5_d = PROD_W'(e4_q);
      td5_d = PROD_W'(c4_q);
    end else if (sn4_q < 0) begin
      sd5_d = den4_q;
      sn5_d = '0;
      tn5_d = PROD_W'(e4_q);
      td5_d = PROD_W'(c4_q);
    end else if (sn4_q > den4_q) begin
      sd5_d = den4_q;
      sn5_d = den4_q;
      tn5_d = PROD_W'(e4_q) + PROD_W'(b4_q);
      td5_d = PROD_W'(c4_q);
    end else begin
      sd5_d = den4_q;
      sn5_d = sn4_q;
      tn5_d = tn4_q;
      td5_d = den4_q;
    end
  end

  // Divider operands. A clamped parameter of one is sent as 1/1 and a zero as
  // 0/1, so the dividers only ever see 0 <= num <= den with den nonzero.
  logic signed [PROD_W-1:0] sc_num, sc_den, tc_num, tc_den;
  logic                     sc_zero, tc_zero, degen6;

  always_comb begin
    sc_num = '0;
    sc_den = PROD_W'(1);
    tc_num = '0;
    tc_den = PROD_W'(1);
    if (tn5_q < 0) begin
      if (ed0_q < 0) begin
        sc_num = '0;
      end else if (ed0_q > EDGE_W'(a5_q)) begin
        sc_num = PROD_W'(1);
      end else begin
        sc_num = PROD_W'(ed0_q);
        sc_den = PROD_W'(a5_q);
      end
    end else if (tn5_q > td5_q) begin
      tc_num = PROD_W'(1);
      if (ed1_q < 0) begin
        sc_num = '0;
      end else if (ed1_q > EDGE_W'(a5_q)) begin
        sc_num = PROD_W'(1);
      end else begin
        sc_num = PROD_W'(ed1_q);
        sc_den = PROD_W'(a5_q);
      end
    end else begin
      tc_num = tn5_q;
      tc_den = td5_q;
      sc_num = sn5_q;
      sc_den = sd5_q;
    end
    // A zero divisor comes from a zero-length segment: the quotient is forced to 0.
    sc_zero = (sc_den == '0);
    tc_zero = (tc_den == '0);
    degen6  = sc_zero || tc_zero;
    if (sc_zero) begin
      sc_num = '0;
      sc_den = PROD_W'(1);
    end
    if (tc_zero) begin
      tc_num = '0;
      tc_den = PROD_W'(1);
    end
  end

  logic [PARAM_W-1:0] sc_div, tc_div;

  spsd_div_pipe u_div_sc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (sc_num[DIV_W-1:0]),
    .den_i (sc_den[DIV_W-1:0]),
    .quo_o (sc_div)
  );

  spsd_div_pipe u_div_tc (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (tc_num[DIV_W-1:0]),
    .den_i (tc_den[DIV_W-1:0]),
    .quo_o (tc_div)
  );

  // Vectors and the degenerate flag travel beside the dividers.
  side_t side_q [0:DIV_LAT-1];

  // D1: vector between the closest points, scaled by 2^F.
  logic signed [C_W-1:0] p_sux, p_suy, p_tvx, p_tvy, cx_d, cy_d, cx_q, cy_q;
  logic [PARAM_W-1:0]    sc1_q, tc1_q;
  logic                  dg1_q;
  vec_t                  vd;

  assign vd    = side_q[DIV_LAT-1].vec;
  assign p_sux = $signed({1'b0, sc_div}) * vd.ux;
  assign p_suy = $signed({1'b0, sc_div}) * vd.uy;
  assign p_tvx = $signed({1'b0, tc_div}) * vd.vx;
  assign p_tvy = $signed({1'b0, tc_div}) * vd.vy;
  assign cx_d  = (C_W'(vd.wx) <<< PARAM_FRAC_BITS) + p_sux - p_tvx;
  assign cy_d  = (C_W'(vd.wy) <<< PARAM_FRAC_BITS) + p_suy - p_tvy;

  // D2: squares.
  logic signed [CSQ_W-1:0] dx_q, dy_q;
  logic [PARAM_W-1:0]      sc2_q, tc2_q;
  logic                    dg2_q;

  // Output stage: drop the 2F fraction bits and saturate.
  logic [CSQ_W:0]        dsum;
  logic [DIST_W-1:0]     dist_d, dist_q;
  logic [PARAM_W-1:0]    sco_q, tco_q;
  logic                  dgo_q;

  always_comb begin
    dsum = {1'b0, $unsigned(dx_q)} + {1'b0, $unsigned(dy_q)};
    if (|dsum[CSQ_W:DIST_W+2*PARAM_FRAC_BITS]) begin
      dist_d = '1;
    end else begin
      dist_d = dsum[DIST_W+2*PARAM_FRAC_BITS-1:2*PARAM_FRAC_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q  <= s1_d;

      a2_q  <= DOT_W'(m_uux) + DOT_W'(m_uuy);
      b2_q  <= DOT_W'(m_uvx) + DOT_W'(m_uvy);
      c2_q  <= DOT_W'(m_vvx) + DOT_W'(m_vvy);
      d2_q  <= DOT_W'(m_uwx) + DOT_W'(m_uwy);
      e2_q  <= DOT_W'(m_vwx) + DOT_W'(m_vwy);
      s2_q  <= s1_q;

      ac3_q <= a2_q * c2_q;
      bb3_q <= b2_q * b2_q;
      be3_q <= b2_q * e2_q;
      cd3_q <= c2_q * d2_q;
      ae3_q <= a2_q * e2_q;
      bd3_q <= b2_q * d2_q;
      a3_q  <= a2_q;
      b3_q  <= b2_q;
      c3_q  <= c2_q;
      d3_q  <= d2_q;
      e3_q  <= e2_q;
      s3_q  <= s2_q;

      den4_q <= ac3_q - bb3_q;
      sn4_q  <= be3_q - cd3_q;
      tn4_q  <= ae3_q - bd3_q;
      par4_q <= ($unsigned(ac3_q - bb3_q) <= PROD_W'(eps_q));
      a4_q   <= a3_q;
      b4_q   <= b3_q;
      c4_q   <= c3_q;
      d4_q   <= d3_q;
      e4_q   <= e3_q;
      s4_q   <= s3_q;

      sd5_q <= sd5_d;
      sn5_q <= sn5_d;
      tn5_q <= tn5_d;
      td5_q <= td5_d;
      ed0_q <= ed0_d;
      ed1_q <= ed1_d;
      a5_q  <= a4_q;
      s5_q  <= s4_q;

      side_q[0] <= '{vec: s5_q, degen: degen6};
      for (int k = 1; k < DIV_LAT; k++) begin
        side_q[k] <= side_q[k-1];
      end

      cx_q  <= cx_d;
      cy_q  <= cy_d;
      sc1_q <= sc_div;
      tc1_q <= tc_div;
      dg1_q <= side_q[DIV_LAT-1].degen;

      dx_q  <= cx_q * cx_q;
      dy_q  <= cy_q * cy_q;
      sc2_q <= sc1_q;
      tc2_q <= tc1_q;
      dg2_q <= dg1_q;

      dist_q <= dist_d;
      sco_q  <= sc2_q;
      tco_q  <= tc2_q;
      dgo_q  <= dg2_q;
    end
  end

  assign m_axis_tdata_o = OUT_TDATA_W'({dist_q, tco_q, sco_q});
  assign m_axis_tuser_o = dgo_q;

  // The denominator a*c - b*b can never go negative.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> !den4_q[PROD_W-1])
    else $error("negative denominator");

  // The dividers only see nonnegative fractions of at most one with a nonzero divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_S5] |-> (sc_num <= sc_den) && (tc_num <= tc_den) && (sc_den != '0) &&
                     (tc_den != '0) && (sc_num >= 0) && (tc_num >= 0))
    else $error("divider operands out of range");

  // Parameters never exceed one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (sco_q <= PARAM_ONE) && (tco_q <= PARAM_ONE))
    else $error("parameter above one");

  // A degenerate result has at least one forced-zero parameter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && dgo_q) |-> (sco_q == '0) || (tco_q == '0))
    else $error("degenerate flag without a zero parameter");

  // An item taken at the input appears in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted item lost at entry");

  // Stage ST_DIV marks where the divider results line up with their side data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[ST_DIV]) |=> vld_q[ST_DIV+1])
    else $error("item lost after the dividers");

endmodule
`default_nettype wire

FILE: sv/spsd_div_pipe.sv
`default_nettype none
module spsd_div_pipe (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [spsd_pkg::DIV_W-1:0]    num_i,
  input  wire logic [spsd_pkg::DIV_W-1:0]    den_i,
  output logic      [spsd_pkg::PARAM_W-1:0]  quo_o
);
  import spsd_pkg::*;

  // Restoring division of num * 2^F by den, for 0 <= num <= den and den > 0.
  // Stage 0 captures the operands; stage k resolves quotient bit PARAM_W-k.
  logic [DIV_W-1:0]   rem_q [0:PARAM_W-1];
  logic [DIV_W-1:0]   den_q [0:PARAM_W-1];
  logic [PARAM_W-1:0] quo_q [0:PARAM_W];

  logic [DIV_W-1:0]   trial [1:PARAM_W];
  logic               ge    [1:PARAM_W];
  logic [DIV_W-1:0]   rem_d [1:PARAM_W];

  always_comb begin
    for (int k = 1; k <= PARAM_W; k++) begin
      // The first step compares num itself, later steps bring in a zero.
      trial[k] = (k == 1) ? rem_q[k-1] : (rem_q[k-1] << 1);
      ge[k]    = (trial[k] >= den_q[k-1]);
      rem_d[k] = ge[k] ? (trial[k] - den_q[k-1]) : trial[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      for (int k = 1; k <= PARAM_W; k++) begin
        quo_q[k] <= {quo_q[k-1][PARAM_W-2:0], ge[k]};
        if (k < PARAM_W) begin
          rem_q[k] <= rem_d[k];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[PARAM_W];

endmodule
`default_nettype wire

FILE: tb/segment_pair_distance_squared_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module segment_pair_distance_squared_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  input  wire logic                             s_axis_tready_i,
  input  wire logic [spsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                             m_axis_tvalid_i,
  input  wire logic                             m_axis_tready_i,
  input  wire logic [spsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i,
  input  wire logic [0:0]                       m_axis_tuser_i,
  input  wire logic                             cfg_wr_en_i,
  input  wire logic [spsd_pkg::EPS_W-1:0]       cfg_wr_data_i,
  output int                                    fail_count_o,
  output int                                    pending_o,
  output int                                    results_seen_o,
  output int                                    degen_seen_o
);
  import spsd_pkg::*;

  typedef struct packed {
    logic               degen;
    logic [DIST_W-1:0]  dist_sq;
    logic [PARAM_W-1:0] tparam;
    logic [PARAM_W-1:0] sparam;
  } closest_t;

  localparam longint ONE = longint'(1) << PARAM_FRAC_BITS;

  closest_t         closest_q[$];
  logic [EPS_W-1:0] eps;

  // Floor of num * 2^F / den, clamped to one; zero divisor raises the flag.
  function automatic longint param_quot(logic signed [127:0] num,
                                        logic signed [127:0] den, ref bit degen);
    logic signed [127:0] q;
    if (num < 0 || den < 0) return 0;
    if (den == 0) begin
      degen = 1;
      return 0;
    end
    q = (num <<< PARAM_FRAC_BITS) / den;
    return (q > ONE) ? ONE : longint'(q);
  endfunction

  function automatic longint edge_quot(longint num, longint den, ref bit degen);
    if (num < 0) return 0;
    if (num > den) return ONE;
    return param_quot(num, den, degen);
  endfunction

  function automatic closest_t predict_closest(logic [IN_TDATA_W-1:0] pts);
    longint c[8];
    longint ux, uy, vx, vy, wx, wy, a, b, cc, d, e, sc, tc;
    logic signed [127:0] den, mag, sn, sd, tn, td, cx, cy, dsq;
    bit dg;
    closest_t r;
    dg = 0;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(pts[i*COORD_BITS +: COORD_BITS]));
    ux = c[2] - c[0]; uy = c[3] - c[1];
    vx = c[6] - c[4]; vy = c[7] - c[5];
    wx = c[0] - c[4]; wy = c[1] - c[5];
    a = ux*ux + uy*uy; b = ux*vx + uy*vy; cc = vx*vx + vy*vy;
    d = ux*wx + uy*wy; e = vx*wx + vy*wy;
    den = 128'(a) * 128'(cc) - 128'(b) * 128'(b);
    mag = den < 0 ? -den : den;
    if (mag <= 128'(eps)) begin
      // Parallel: slide along the second segment from the first one's start.
      sd = cc; td = cc; sn = 0; tn = e;
    end else begin
      sd = den; td = den;
      sn = 128'(b) * 128'(e) - 128'(cc) * 128'(d);
      tn = 128'(a) * 128'(e) - 128'(b) * 128'(d);
      if (sn < 0) begin
        sn = 0; tn = e; td = cc;
      end else if (sn > sd) begin
        sn = sd; tn = e + b; td = cc;
      end
    end
    if (tn < 0) begin
      tc = 0; sc = edge_quot(-d, a, dg);
    end else if (tn > td) begin
      tc = ONE; sc = edge_quot(b - d, a, dg);
    end else begin
      tc = param_quot(tn, td, dg);
      sc = param_quot(sn, sd, dg);
    end
    cx = 128'(wx*ONE + sc*ux - tc*vx);
    cy = 128'(wy*ONE + sc*uy - tc*vy);
    dsq = (cx*cx + cy*cy) >>> (2*PARAM_FRAC_BITS);
    r.sparam  = sc[PARAM_W-1:0];
    r.tparam  = tc[PARAM_W-1:0];
    r.dist_sq = (dsq >= (128'(1) << DIST_W)) ? '1 : dsq[DIST_W-1:0];
    r.degen   = dg;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    closest_t want, got;
    if (!rst_ni) begin
      eps            <= '0;
      fail_count_o   <= 0;
      results_seen_o <= 0;
      degen_seen_o   <= 0;
    end else begin
      if (cfg_wr_en_i) eps <= cfg_wr_data_i;
      if (s_axis_tvalid_i && s_axis_tready_i) closest_q.push_back(predict_closest(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tuser_i[0], m_axis_tdata_i[OUT_FIELD_W-1:0]};
        results_seen_o <= results_seen_o + 1;
        if (got.degen) degen_seen_o <= degen_seen_o + 1;
        if (closest_q.size() == 0) begin
          if (fail_count_o < 10) $display("ERROR: result item with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = closest_q.pop_front();
          if (got != want || m_axis_tdata_i[OUT_TDATA_W-1:OUT_FIELD_W] != 0) begin
            if (fail_count_o < 10)
              $display("ERROR: sc %h/%h tc %h/%h dist %h/%h degen %b/%b (exp/act)",
                       want.sparam, got.sparam, want.tparam, got.tparam,
                       want.dist_sq, got.dist_sq, want.degen, got.degen);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o <= closest_q.size();
  end
endmodule
`default_nettype wire

FILE: tb/segment_pair_distance_squared_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module segment_pair_distance_squared_tb;
  import spsd_pkg::*;

  localparam int LATENCY     = 26;
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i = '0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic [0:0]              m_axis_tuser_o;
  logic                    cfg_wr_en_i = 1'b0;
  logic [EPS_W-1:0]        cfg_wr_data_i = '0;
  int                      fail_count, pending, results_seen, degen_seen;
  int                      cycle_count = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      items_sent = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  segment_pair_distance_squared uut (.*);

  segment_pair_distance_squared_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i,
    .m_axis_tdata_i(m_axis_tdata_o), .m_axis_tuser_i(m_axis_tuser_o),
    .cfg_wr_en_i, .cfg_wr_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .results_seen_o(results_seen), .degen_seen_o(degen_seen));

  // The receiver stalls at random; it changes tready on falling edges only.
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Presents one item and holds it until the block takes it. Random idle
  // cycles come before the item, so valid never drops between back-to-back items.
  task automatic send_pair(logic [IN_TDATA_W-1:0] pts);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pts;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Drops valid and waits for every expected result, then for the pipeline depth.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_epsilon(logic [EPS_W-1:0] value);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(negedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_pts(int p0x, int p0y, int p1x, int p1y,
                                                     int q0x, int q0y, int q1x, int q1y);
    return {16'(q1y), 16'(q1x), 16'(q0y), 16'(q0x), 16'(p1y), 16'(p1x), 16'(p0y), 16'(p0x)};
  endfunction

  // Random pairs: mostly small coordinates, sometimes full range, sometimes
  // collapsed or parallel segments.
  function automatic logic [IN_TDATA_W-1:0] random_pair();
    logic [IN_TDATA_W-1:0] pts;
    int dx, dy, k;
    for (int i = 0; i < 8; i++)
      pts[i*16 +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
                                                 : 16'($signed(10'($urandom)));
    case ($urandom_range(7))
      0: pts[47:32] = pts[15:0];
      1: pts[127:96] = pts[95:64];
      2: begin
        dx = $signed(pts[47:32]) - $signed(pts[15:0]);
        dy = $signed(pts[63:48]) - $signed(pts[31:16]);
        k = $urandom_range(1, 3);
        pts[111:96]  = 16'($signed(pts[79:64]) + dx / k);
        pts[127:112] = 16'($signed(pts[95:80]) + dy / k);
        pts[63:32]   = {16'($signed(pts[31:16]) + (dy / k) * k),
                        16'($signed(pts[15:0]) + (dx / k) * k)};
      end
      default: ;
    endcase
    return pts;
  endfunction

  initial begin
    int n;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs at reset epsilon: crossing, disjoint, collinear, points
    // and the coordinate extremes.
    send_idle_pct = 14;
    recv_idle_pct = 78;
    send_pair(pack_pts(0, 0, 256, 256, 0, 256, 256, 0));
    send_pair(pack_pts(0, 0, 256, 0, 0, 512, 256, 512));
    send_pair(pack_pts(0, 0, 256, 0, 512, 0, 768, 0));
    send_pair(pack_pts(0, 0, 256, 0, -512, 0, -256, 0));
    send_pair(pack_pts(10, 10, 10, 10, 0, 0, 100, 0));
    send_pair(pack_pts(0, 0, 100, 0, 50, 50, 50, 50));
    send_pair(pack_pts(7, 7, 7, 7, -3, 9, -3, 9));
    send_pair(pack_pts(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
    send_pair(pack_pts(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
    send_pair(pack_pts(-32768, 32767, -32768, -32768, 32767, -32768, 32767, 32767));
    send_pair(pack_pts(0, 0, 1000, 0, 2000, 10, 3000, 500));
    send_pair(pack_pts(0, 0, 1000, 0, -3000, 10, -2000, -500));
    send_pair(pack_pts(0, 0, 1000, 1, 0, 100, 1000, 100));
    send_pair('1);
    send_pair('0);
    send_pair({8{16'h5555}});
    send_pair({8{16'hAAAA}});
    drain();

    // Near-parallel pairs under a range of epsilon settings, extremes included.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_epsilon(32'hFFFF_FFFF);
        1: write_epsilon(32'd1000);
        2: write_epsilon($urandom);
        default: write_epsilon('0);
      endcase
      if (phase == 1) begin
        send_idle_pct = 78;
        recv_idle_pct = 14;
      end else if (phase == 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_pair(pack_pts(0, 0, 1000, 1, 0, 100, 1000, 100));
      send_pair(pack_pts(0, 0, 256, 0, 512, 3, 768, 3));
      n = (phase == 3) ? 300 : 200;
      for (int i = 0; i < n; i++) begin
        send_pair(random_pair());
        // Let the pipeline empty once in the middle of a phase.
        if (phase == 0 && i == 100) drain();
      end
      drain();
    end

    $display("Sent %0d segment pairs over four epsilon settings, %0d results checked,",
             items_sent, results_seen);
    $display("%0d of them flagged degenerate.", degen_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
